>>> rtl/core/mpp_pkg.sv
// shared widths, register indexes and result type for the masked port pattern player
package mpp_pkg;

    localparam int PORT_W    = 16;
    localparam int DELAY_W   = 16;
    localparam int TICKS_W   = 32;
    localparam int IDX_W     = $clog2(PORT_W);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_MASK     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PORT = 1'd1;

    localparam logic [PORT_W-1:0] BIT_MASK_RESET     = 16'hFFFF;
    localparam logic [PORT_W-1:0] INITIAL_PORT_RESET = 16'h0000;

    typedef logic [PORT_W-1:0] port_t;

    typedef struct packed {
        logic [TICKS_W-1:0] delay_ticks;
        port_t              port_value;
    } result_t;

endpackage

>>> rtl/core/mpp_deposit.sv
// masked bit deposit: the k-th set mask bit takes raw bit k, other bits keep the held value
module mpp_deposit (
    input  mpp_pkg::port_t held,
    input  mpp_pkg::port_t mask,
    input  mpp_pkg::port_t raw,
    output mpp_pkg::port_t port_value
);
    import mpp_pkg::*;

    logic [IDX_W-1:0] raw_idx [PORT_W];

    // raw bit index for each port position: number of set mask bits below it
    always_comb begin
        for (int pos = 0; pos < PORT_W; pos++) begin
            raw_idx[pos] = '0;
            for (int j = 0; j < pos; j++) begin
                raw_idx[pos] = raw_idx[pos] + IDX_W'(mask[j]);
            end
        end
    end

    always_comb begin
        for (int pos = 0; pos < PORT_W; pos++) begin
            port_value[pos] = mask[pos] ? raw[raw_idx[pos]] : held[pos];
        end
    end

endmodule

>>> rtl/core/masked_port_pattern_player.sv
// Masked port pattern player: each 32-bit pattern word (raw bits, delay) is registered on
// entry, its raw bits are scattered into the mask positions of the held port value, and the
// new port value with its delay is registered at the output; the delay is shifted left 16
// when the raw bits equal those of the word before. One word per clock is accepted and one
// result per clock is delivered while m_tready does not stall the output; a word passes the input
// register and then the result register around the single deposit-and-compare stage. A write to
// initial_port also reloads the held port value. The repeat history survives tlast.
module masked_port_pattern_player (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [mpp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mpp_pkg::CFG_W-1:0]            cfg_wdata,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [31:0]                          s_tdata,  // raw_port_bits[15:0], delay_field[31:16]
    input  logic                                 s_tlast,  // last_word
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [47:0]                          m_tdata,  // port_value[15:0], delay_ticks[47:16]
    output logic                                 m_tlast   // end_of_sequence
);
    import mpp_pkg::*;

    // configuration and state
    port_t bit_mask_reg,  bit_mask_next;
    port_t held_port_reg, held_port_next;
    port_t prev_raw_reg,  prev_raw_next;
    logic  prev_valid_reg, prev_valid_next;

    // input stage
    logic               in_valid_reg;
    port_t              in_raw_reg;
    logic [DELAY_W-1:0] in_delay_reg;
    logic               in_last_reg;

    // output stage
    logic    out_valid_reg;
    result_t out_res_reg, out_res_next;
    logic    out_last_reg;

    logic  advance;
    logic  accept;
    logic  repeat_word;
    port_t dep_port;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    mpp_deposit u_deposit (
        .held       (held_port_reg),
        .mask       (bit_mask_reg),
        .raw        (in_raw_reg),
        .port_value (dep_port)
    );

    assign repeat_word = prev_valid_reg && (prev_raw_reg == in_raw_reg);

    always_comb begin
        out_res_next.port_value = dep_port;
        if (repeat_word) begin
            out_res_next.delay_ticks = {in_delay_reg, {(TICKS_W-DELAY_W){1'b0}}};
        end else begin
            out_res_next.delay_ticks = {{(TICKS_W-DELAY_W){1'b0}}, in_delay_reg};
        end
    end

    always_comb begin
        bit_mask_next   = bit_mask_reg;
        held_port_next  = held_port_reg;
        prev_raw_next   = prev_raw_reg;
        prev_valid_next = prev_valid_reg;
        if (advance) begin
            held_port_next  = dep_port;
            prev_raw_next   = in_raw_reg;
            prev_valid_next = 1'b1;
        end
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_BIT_MASK: begin
                    bit_mask_next = cfg_wdata[PORT_W-1:0];
                end
                REG_INITIAL_PORT: begin
                    held_port_next = cfg_wdata[PORT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_mask_reg   <= BIT_MASK_RESET;
            held_port_reg  <= INITIAL_PORT_RESET;
            prev_raw_reg   <= '0;
            prev_valid_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            bit_mask_reg   <= bit_mask_next;
            held_port_reg  <= held_port_next;
            prev_raw_reg   <= prev_raw_next;
            prev_valid_reg <= prev_valid_next;
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_raw_reg   <= s_tdata[PORT_W-1:0];
            in_delay_reg <= s_tdata[PORT_W+DELAY_W-1:PORT_W];
            in_last_reg  <= s_tlast;
        end
        if (advance) begin
            out_res_reg  <= out_res_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;
    assign m_tlast  = out_last_reg;

    // a transaction moved into the result register is presented next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result register not loaded after advance");

    // port bits outside the mask keep the held value
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (((out_res_reg.port_value ^ $past(held_port_reg))
                      & ~$past(bit_mask_reg)) == '0))
        else $error("unmasked port bit changed");

    // a delay is either the plain field or the field shifted by 16
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_res_reg.delay_ticks[TICKS_W-1:DELAY_W] == '0 ||
                      out_res_reg.delay_ticks[DELAY_W-1:0] == '0))
        else $error("delay has bits in both halves");

    // both stages full and output stalled: no new transaction taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted with pipeline full");

    // held port follows the deposited value after each advance without a config write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !cfg_wr_en) |=> (held_port_reg == out_res_reg.port_value))
        else $error("held port out of step with result");

endmodule
